// File: sv/brp_pkg.sv
// ----------------------------------------------------------------------------
// brp_pkg
// Shared types and constants for the base relocation parser: status codes,
// register indexes, fixup kinds and the record passed from parser to formatter.
// ----------------------------------------------------------------------------
package brp_pkg;

	// Status codes reported with every result
	typedef enum logic [2:0] {
		ST_BUSY   = 3'd0,
		ST_DONE   = 3'd1,
		ST_NODIR  = 3'd2,
		ST_DIROVF = 3'd3,
		ST_BLKOVF = 3'd4,
		ST_PAGE   = 3'd5,
		ST_TYPE   = 3'd6
	} status_t;

	// Configuration register indexes
	localparam logic [2:0] REG_IMAGE_SIZE = 3'd0;
	localparam logic [2:0] REG_LOAD_ADJ   = 3'd1;
	localparam logic [2:0] REG_DIR_OFFSET = 3'd2;
	localparam logic [2:0] REG_DIR_SIZE   = 3'd3;
	localparam logic [2:0] REG_DIR_COUNT  = 3'd4;

	// Request action codes
	localparam logic ACT_BEGIN    = 1'b0;
	localparam logic ACT_HALFWORD = 1'b1;

	// Header phase: 0..3 are header halfwords, then entries
	localparam logic [2:0] PHASE_PAGE_LO  = 3'd0;
	localparam logic [2:0] PHASE_PAGE_HI  = 3'd1;
	localparam logic [2:0] PHASE_SIZE_LO  = 3'd2;
	localparam logic [2:0] PHASE_SIZE_HI  = 3'd3;
	localparam logic [2:0] PHASE_ENTRIES  = 3'd4;

	// Entry type codes
	localparam logic [3:0] TYPE_PAD     = 4'd0;
	localparam logic [3:0] TYPE_HIGH    = 4'd1;
	localparam logic [3:0] TYPE_LOW     = 4'd2;
	localparam logic [3:0] TYPE_HIGHLOW = 4'd3;
	localparam logic [3:0] TYPE_DIR64   = 4'd10;

	// Largest rejected directory count and minimum block size
	localparam logic [4:0]  MIN_DIR_COUNT  = 5'd5;
	localparam logic [31:0] MIN_BLOCK_SIZE = 32'd8;
	localparam logic [31:0] HEADER_BACKUP  = 32'd6;

	// Access widths
	localparam logic [1:0] WIDTH_16 = 2'd0;
	localparam logic [1:0] WIDTH_32 = 2'd1;
	localparam logic [1:0] WIDTH_64 = 2'd2;

	typedef enum logic [1:0] {
		KIND_HIGH    = 2'd0,
		KIND_LOW     = 2'd1,
		KIND_HIGHLOW = 2'd2,
		KIND_DIR64   = 2'd3
	} fix_kind_t;

	// Register file contents
	typedef struct packed {
		logic [31:0] image_size;
		logic [63:0] load_adjust;
		logic [31:0] dir_offset;
		logic [31:0] dir_size;
		logic [4:0]  dir_count;
	} cfg_t;

	// Classified request handed from parser to formatter
	typedef struct packed {
		logic        fix;
		fix_kind_t   kind;
		logic [32:0] offset;
		status_t     status;
	} entry_t;

	// True when less than one halfword remains before the directory end
	function automatic logic dir_done(input logic [31:0] pos, input logic [32:0] dir_end);
		return ({1'b0, pos} + 33'd1) >= dir_end;
	endfunction

endpackage

// File: sv/base_relocation_parser.sv
// ----------------------------------------------------------------------------
// base_relocation_parser
// Walks a base relocation directory streamed as halfwords and emits one
// fixup descriptor with the running status for every request.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    action, halfword
//  out      out_valid / out_stall  fixup_valid, fixup_offset, fixup_width,
//                                  addend, status
//  cfg      cfg_we                 cfg_index, cfg_data
//
// One request per cycle while in_stall is low; a result is written into the
// queue when its request is accepted and moves to the output register once
// the output register is empty or being taken.
// The parser state advances once per accepted request; a queue of
// QUEUE_DEPTH records sits between parser and output register.
// in_stall rises only when the queue is full; out_stall holds the output.
// Reset clears the registers, parse state and control to zero with status
// busy; queue and output data hold until written.
// ----------------------------------------------------------------------------
module base_relocation_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [15:0] halfword,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        fixup_valid,
	output logic [32:0] fixup_offset,
	output logic [1:0]  fixup_width,
	output logic [63:0] addend,
	output logic [2:0]  status
);
	import brp_pkg::*;

	cfg_t   cfg_q;
	logic   push;
	logic   pop;
	logic   q_full;
	logic   q_empty;
	entry_t push_data;
	entry_t pop_data;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_SIZE: cfg_q.image_size  <= cfg_data[31:0];
				REG_LOAD_ADJ:   cfg_q.load_adjust <= cfg_data;
				REG_DIR_OFFSET: cfg_q.dir_offset  <= cfg_data[31:0];
				REG_DIR_SIZE:   cfg_q.dir_size    <= cfg_data[31:0];
				REG_DIR_COUNT:  cfg_q.dir_count   <= cfg_data[4:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	assign in_stall = q_full;

	brp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.q_full    (q_full),
		.action    (action),
		.halfword  (halfword),
		.push      (push),
		.push_data (push_data)
	);

	brp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	brp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_adjust  (cfg_q.load_adjust),
		.q_empty      (q_empty),
		.q_data       (pop_data),
		.pop          (pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.fixup_valid  (fixup_valid),
		.fixup_offset (fixup_offset),
		.fixup_width  (fixup_width),
		.addend       (addend),
		.status       (status)
	);

endmodule

// File: sv/brp_front.sv
// ----------------------------------------------------------------------------
// brp_front
// Parser stage: accepts requests, tracks header phase and block bounds,
// classifies each entry and pushes one record per request into the queue.
// ----------------------------------------------------------------------------
module brp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  brp_pkg::cfg_t  cfg,
	input  logic           in_valid,
	input  logic           q_full,
	input  logic           action,
	input  logic [15:0]    halfword,
	output logic           push,
	output brp_pkg::entry_t push_data
);
	import brp_pkg::*;

	logic [2:0]  phase_q;
	logic [31:0] page_q;
	logic [31:0] bsize_q;
	logic [31:0] pos_q;
	logic [31:0] bend_q;
	status_t     status_q;

	logic [2:0]  phase_d;
	logic [31:0] page_d;
	logic [31:0] bsize_d;
	logic [31:0] pos_d;
	logic [31:0] bend_d;
	status_t     status_d;

	logic [32:0] dir_end;
	logic [31:0] pos_inc;
	logic [31:0] bsize_full;
	logic [31:0] bstart;
	logic [32:0] blk_end;
	logic [3:0]  etype;
	logic        fix;
	fix_kind_t   kind;
	logic [32:0] fix_off;

	assign push = in_valid & ~q_full;

	// Shared address arithmetic
	always_comb begin
		dir_end    = {1'b0, cfg.dir_offset} + {1'b0, cfg.dir_size};
		pos_inc    = pos_q + 32'd2;
		bsize_full = {halfword, bsize_q[15:0]};
		bstart     = pos_q - HEADER_BACKUP;
		blk_end    = {1'b0, bstart} + {1'b0, bsize_full};
		etype      = halfword[15:12];
		fix_off    = {1'b0, page_q} + {21'd0, halfword[11:0]};
	end

	// Next parse state and classification
	always_comb begin
		phase_d  = phase_q;
		page_d   = page_q;
		bsize_d  = bsize_q;
		pos_d    = pos_q;
		bend_d   = bend_q;
		status_d = status_q;
		fix      = 1'b0;
		kind     = KIND_HIGH;
		if (action == ACT_BEGIN) begin
			phase_d = PHASE_PAGE_LO;
			page_d  = '0;
			bsize_d = '0;
			bend_d  = '0;
			pos_d   = cfg.dir_offset;
			if (cfg.dir_count <= MIN_DIR_COUNT) begin
				status_d = ST_NODIR;
			end else if (cfg.dir_offset >= cfg.image_size ||
					(cfg.dir_size != '0 && dir_end > {1'b0, cfg.image_size})) begin
				status_d = ST_DIROVF;
			end else if (dir_done(cfg.dir_offset, dir_end)) begin
				status_d = ST_DONE;
			end else begin
				status_d = ST_BUSY;
			end
		end else if (status_q == ST_BUSY) begin
			pos_d = pos_inc;
			unique case (phase_q)
				PHASE_PAGE_LO: begin
					page_d  = {16'd0, halfword};
					phase_d = PHASE_PAGE_HI;
				end
				PHASE_PAGE_HI: begin
					page_d  = {halfword, page_q[15:0]};
					phase_d = PHASE_SIZE_LO;
				end
				PHASE_SIZE_LO: begin
					bsize_d = {16'd0, halfword};
					phase_d = PHASE_SIZE_HI;
				end
				PHASE_SIZE_HI: begin
					bsize_d = bsize_full;
					if (bsize_full < MIN_BLOCK_SIZE || bsize_full[0] ||
							blk_end > {1'b0, cfg.image_size}) begin
						status_d = ST_BLKOVF;
					end else if (page_q >= cfg.image_size) begin
						status_d = ST_PAGE;
					end else begin
						bend_d  = blk_end[31:0];
						phase_d = PHASE_ENTRIES;
						// Empty block: straight back to the next header
						if ({1'b0, pos_inc} >= blk_end) begin
							phase_d = PHASE_PAGE_LO;
							if (dir_done(pos_inc, dir_end)) status_d = ST_DONE;
						end
					end
				end
				default: begin
					unique case (etype)
						TYPE_PAD:     fix = 1'b0;
						TYPE_HIGH:    begin fix = 1'b1; kind = KIND_HIGH;    end
						TYPE_LOW:     begin fix = 1'b1; kind = KIND_LOW;     end
						TYPE_HIGHLOW: begin fix = 1'b1; kind = KIND_HIGHLOW; end
						TYPE_DIR64:   begin fix = 1'b1; kind = KIND_DIR64;   end
						default:      status_d = ST_TYPE;
					endcase
					if (status_d == ST_BUSY && pos_inc >= bend_q) begin
						phase_d = PHASE_PAGE_LO;
						if (dir_done(pos_inc, dir_end)) status_d = ST_DONE;
					end
				end
			endcase
		end
	end

	// Record for the formatter
	always_comb begin
		push_data.fix    = fix;
		push_data.kind   = kind;
		push_data.offset = fix_off;
		push_data.status = status_d;
	end

	// Advance parse state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PHASE_PAGE_LO;
			page_q   <= '0;
			bsize_q  <= '0;
			pos_q    <= '0;
			bend_q   <= '0;
			status_q <= ST_BUSY;
		end else if (push) begin
			phase_q  <= phase_d;
			page_q   <= page_d;
			bsize_q  <= bsize_d;
			pos_q    <= pos_d;
			bend_q   <= bend_d;
			status_q <= status_d;
		end
	end

endmodule

// File: sv/brp_queue.sv
// ----------------------------------------------------------------------------
// brp_queue
// Small FIFO of classified records between parser and formatter.
// ----------------------------------------------------------------------------
module brp_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  brp_pkg::entry_t push_data,
	input  logic            pop,
	output brp_pkg::entry_t pop_data,
	output logic            full,
	output logic            empty
);
	import brp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	entry_t        mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem[rd_ptr_q];

	// Store incoming record
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: sv/brp_back.sv
// ----------------------------------------------------------------------------
// brp_back
// Formatter stage: pops records, builds the width and addend from the load
// adjustment and holds the result in the output register.
// ----------------------------------------------------------------------------
module brp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [63:0]     load_adjust,
	input  logic            q_empty,
	input  brp_pkg::entry_t q_data,
	output logic            pop,
	input  logic            out_stall,
	output logic            out_valid,
	output logic            fixup_valid,
	output logic [32:0]     fixup_offset,
	output logic [1:0]      fixup_width,
	output logic [63:0]     addend,
	output logic [2:0]      status
);
	import brp_pkg::*;

	logic        valid_q;
	logic        fix_q;
	logic [32:0] offset_q;
	logic [1:0]  width_q;
	logic [63:0] addend_q;
	status_t     status_q;

	logic [1:0]  width_d;
	logic [63:0] addend_d;

	// Refill the output register when empty or being taken
	assign pop = ~q_empty & (~valid_q | ~out_stall);

	// Select width and addend by fixup kind
	always_comb begin
		width_d  = '0;
		addend_d = '0;
		if (q_data.fix) begin
			unique case (q_data.kind)
				KIND_HIGH: begin
					width_d  = WIDTH_16;
					addend_d = {48'd0, load_adjust[31:16]};
				end
				KIND_LOW: begin
					width_d  = WIDTH_16;
					addend_d = {48'd0, load_adjust[15:0]};
				end
				KIND_HIGHLOW: begin
					width_d  = WIDTH_32;
					addend_d = {32'd0, load_adjust[31:0]};
				end
				KIND_DIR64: begin
					width_d  = WIDTH_64;
					addend_d = load_adjust;
				end
				default: begin
					width_d  = '0;
					addend_d = '0;
				end
			endcase
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			fix_q    <= q_data.fix;
			offset_q <= q_data.fix ? q_data.offset : '0;
			width_q  <= width_d;
			addend_q <= addend_d;
			status_q <= q_data.status;
		end
	end

	assign out_valid    = valid_q;
	assign fixup_valid  = fix_q;
	assign fixup_offset = offset_q;
	assign fixup_width  = width_q;
	assign addend       = addend_q;
	assign status       = status_q;

endmodule

// File: bench/base_relocation_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base_relocation_parser_tb
// Streams relocation directories into the parser and checks every result.
// A short directed table covers reset parsing, the begin checks, each entry
// type and each error code. Randomized directories follow, mostly
// well-formed with random content, plus broken headers and noise. A
// behavioral predictor computes each expected result, and the results are
// compared field by field in order.
// ----------------------------------------------------------------------------
module base_relocation_parser_tb;
	import brp_pkg::*;

	localparam logic [63:0] DIRECTED_ADJUST = 64'h0123_4567_89AB_CDEF;
	localparam int unsigned REQUEST_TARGET  = 1500;
	localparam int unsigned IDLE_PERCENT    = 36;

	// Expected result of one request
	typedef struct packed {
		logic        fv;
		logic [32:0] off;
		logic [1:0]  w;
		logic [63:0] add;
		status_t     st;
	} fixup_t;

	typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		logic [2:0]  reg_idx;
		logic [63:0] value;
		logic        act;
		logic [15:0] hw;
		bit          typed;
		fixup_t      want;
	} plan_row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        action    = ACT_BEGIN;
	logic [15:0] halfword  = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        fixup_valid;
	logic [32:0] fixup_offset;
	logic [1:0]  fixup_width;
	logic [63:0] addend;
	logic [2:0]  status;

	// Predictor copy of the registers and the parse state
	logic [31:0] cf_image   = '0;
	logic [63:0] cf_adjust  = '0;
	logic [31:0] cf_dir_off = '0;
	logic [31:0] cf_dir_len = '0;
	logic [4:0]  cf_dir_cnt = '0;
	logic [2:0]  hdr_step   = PHASE_PAGE_LO;
	logic [31:0] pg_base    = '0;
	logic [31:0] blk_len    = '0;
	logic [31:0] rd_pos     = '0;
	logic [31:0] blk_limit  = '0;
	status_t     cur_status = ST_BUSY;

	fixup_t      expected_fixups[$];
	plan_row_t   directed_rows[$];
	bit          gaps_on         = 1'b1;
	int unsigned fail_count      = 0;
	int unsigned requests_sent   = 0;
	int unsigned acted_requests  = 0;
	int unsigned results_checked = 0;
	int unsigned fixups_checked  = 0;
	int unsigned setups          = 0;

	base_relocation_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.halfword     (halfword),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.fixup_valid  (fixup_valid),
		.fixup_offset (fixup_offset),
		.fixup_width  (fixup_width),
		.addend       (addend),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Bound the run
	initial begin : watchdog
		#2_000_000;
		$display("Run timed out with %0d results outstanding", expected_fixups.size());
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [32:0] dir_limit();
		return {1'b0, cf_dir_off} + {1'b0, cf_dir_len};
	endfunction

	// Finish when less than one halfword remains before the directory end
	function automatic void finish_if_exhausted();
		if ({1'b0, rd_pos} + 33'd1 >= dir_limit())
			cur_status = ST_DONE;
	endfunction

	function automatic void note_config(input logic [2:0] idx, input logic [63:0] val);
		case (idx)
			REG_IMAGE_SIZE: cf_image   = val[31:0];
			REG_LOAD_ADJ:   cf_adjust  = val;
			REG_DIR_OFFSET: cf_dir_off = val[31:0];
			REG_DIR_SIZE:   cf_dir_len = val[31:0];
			REG_DIR_COUNT:  cf_dir_cnt = val[4:0];
			default: ;
		endcase
	endfunction

	function automatic fixup_t predict_fixup(input logic act, input logic [15:0] hw);
		fixup_t      r;
		logic [31:0] start;
		logic [32:0] bend;
		r = '0;
		if (act == ACT_BEGIN) begin
			hdr_step   = PHASE_PAGE_LO;
			pg_base    = '0;
			blk_len    = '0;
			blk_limit  = '0;
			rd_pos     = cf_dir_off;
			cur_status = ST_BUSY;
			if (cf_dir_cnt <= MIN_DIR_COUNT)
				cur_status = ST_NODIR;
			else if (cf_dir_off >= cf_image ||
					(cf_dir_len != 0 && dir_limit() > {1'b0, cf_image}))
				cur_status = ST_DIROVF;
			else
				finish_if_exhausted();
		end else if (cur_status == ST_BUSY) begin
			start  = rd_pos;
			rd_pos = rd_pos + 32'd2;
			case (hdr_step)
				PHASE_PAGE_LO: begin
					pg_base  = {16'h0, hw};
					hdr_step = PHASE_PAGE_HI;
				end
				PHASE_PAGE_HI: begin
					pg_base  = pg_base | {hw, 16'h0};
					hdr_step = PHASE_SIZE_LO;
				end
				PHASE_SIZE_LO: begin
					blk_len  = {16'h0, hw};
					hdr_step = PHASE_SIZE_HI;
				end
				PHASE_SIZE_HI: begin
					// Validate the header once the block size is complete
					blk_len = blk_len | {hw, 16'h0};
					bend    = {1'b0, start - HEADER_BACKUP} + {1'b0, blk_len};
					if (blk_len < MIN_BLOCK_SIZE || blk_len[0] || bend > {1'b0, cf_image}) begin
						cur_status = ST_BLKOVF;
					end else if (pg_base >= cf_image) begin
						cur_status = ST_PAGE;
					end else begin
						blk_limit = bend[31:0];
						hdr_step  = PHASE_ENTRIES;
						if ({1'b0, rd_pos} >= bend) begin
							hdr_step = PHASE_PAGE_LO;
							finish_if_exhausted();
						end
					end
				end
				default: begin
					// Decode one entry
					r.off = {1'b0, pg_base} + {21'h0, hw[11:0]};
					case (hw[15:12])
						TYPE_PAD: ;
						TYPE_HIGH: begin
							r.fv  = 1'b1;
							r.w   = WIDTH_16;
							r.add = {48'h0, cf_adjust[31:16]};
						end
						TYPE_LOW: begin
							r.fv  = 1'b1;
							r.w   = WIDTH_16;
							r.add = {48'h0, cf_adjust[15:0]};
						end
						TYPE_HIGHLOW: begin
							r.fv  = 1'b1;
							r.w   = WIDTH_32;
							r.add = {32'h0, cf_adjust[31:0]};
						end
						TYPE_DIR64: begin
							r.fv  = 1'b1;
							r.w   = WIDTH_64;
							r.add = cf_adjust;
						end
						default: cur_status = ST_TYPE;
					endcase
					if (cur_status == ST_BUSY && rd_pos >= blk_limit) begin
						hdr_step = PHASE_PAGE_LO;
						finish_if_exhausted();
					end
				end
			endcase
		end
		if (!r.fv) begin
			r.off = '0;
			r.w   = '0;
			r.add = '0;
		end
		r.st = cur_status;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	function automatic void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Vary the output stall on the falling edge
	always @(negedge clk)
		out_stall <= gaps_on && ($urandom_range(0, 99) < IDLE_PERCENT);

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		fixup_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_fixups.size() == 0) begin
				$error("result with nothing expected: status %0d", status);
				fail_count++;
			end else begin
				want = expected_fixups.pop_front();
				compare_field("fixup_valid", 64'(want.fv), 64'(fixup_valid));
				compare_field("fixup_offset", 64'(want.off), 64'(fixup_offset));
				compare_field("fixup_width", 64'(want.w), 64'(fixup_width));
				compare_field("addend", want.add, addend);
				compare_field("status", 64'(want.st), 64'(status));
				results_checked++;
				if (want.fv)
					fixups_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Request driving (every task starts and ends at a falling edge)
	// ------------------------------------------------------------------

	task automatic push_request(input logic act, input logic [15:0] hw, input bit typed,
			input fixup_t want);
		fixup_t guess;
		while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		action   = act;
		halfword = hw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (act == ACT_BEGIN || cur_status == ST_BUSY)
			acted_requests++;
		requests_sent++;
		guess = predict_fixup(act, hw);
		expected_fixups.push_back(typed ? want : guess);
		@(negedge clk);
	endtask

	task automatic send(input logic act, input logic [15:0] hw);
		push_request(act, hw, 1'b0, '0);
	endtask

	// Hold off until every expected result has come back
	task automatic wait_idle();
		in_valid = 1'b0;
		while (expected_fixups.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		note_config(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------

	function automatic void add_write(input logic [2:0] idx, input logic [63:0] val);
		plan_row_t row;
		row         = '{kind: ROW_WRITE, default: '0};
		row.kind    = ROW_WRITE;
		row.reg_idx = idx;
		row.value   = val;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_req(input logic act, input logic [15:0] hw);
		plan_row_t row;
		row      = '{kind: ROW_REQUEST, default: '0};
		row.kind = ROW_REQUEST;
		row.act  = act;
		row.hw   = hw;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_check(input logic act, input logic [15:0] hw, input logic fv,
			input logic [32:0] off, input logic [1:0] w, input logic [63:0] add,
			input status_t st);
		plan_row_t row;
		row         = '{kind: ROW_REQUEST, default: '0};
		row.kind    = ROW_REQUEST;
		row.act     = act;
		row.hw      = hw;
		row.typed   = 1'b1;
		row.want.fv  = fv;
		row.want.off = off;
		row.want.w   = w;
		row.want.add = add;
		row.want.st  = st;
		directed_rows.push_back(row);
	endfunction

	function automatic void build_directed();
		// Halfword straight after reset, then begin with too few directories
		add_check(ACT_HALFWORD, 16'h0000, 1'b0, '0, '0, '0, ST_BUSY);
		add_check(ACT_BEGIN, 16'h0000, 1'b0, '0, '0, '0, ST_NODIR);
		// Directory offset not inside an empty image
		add_write(REG_DIR_COUNT, 64'd16);
		add_check(ACT_BEGIN, 16'h0000, 1'b0, '0, '0, '0, ST_DIROVF);
		// Empty directory finishes at once; later halfwords are ignored
		add_write(REG_IMAGE_SIZE, 64'hFFFF_FFFF);
		add_write(REG_DIR_OFFSET, 64'h100);
		add_check(ACT_BEGIN, 16'h0000, 1'b0, '0, '0, '0, ST_DONE);
		add_check(ACT_HALFWORD, 16'hFFFF, 1'b0, '0, '0, '0, ST_DONE);
		// Directory running past the image end
		add_write(REG_DIR_SIZE, 64'hFFFF_FFFF);
		add_check(ACT_BEGIN, 16'hFFFF, 1'b0, '0, '0, '0, ST_DIROVF);
		// One block with every fixup type, then a short second block
		add_write(REG_DIR_SIZE, 64'h40);
		add_write(REG_LOAD_ADJ, DIRECTED_ADJUST);
		add_check(ACT_BEGIN, 16'h0000, 1'b0, '0, '0, '0, ST_BUSY);
		add_req(ACT_HALFWORD, 16'h5000);
		add_req(ACT_HALFWORD, 16'h1234);
		add_req(ACT_HALFWORD, 16'h0012);
		add_req(ACT_HALFWORD, 16'h0000);
		add_check(ACT_HALFWORD, 16'h0000, 1'b0, '0, '0, '0, ST_BUSY);
		add_check(ACT_HALFWORD, 16'h1FFF, 1'b1, 33'h0_1234_5FFF, WIDTH_16, 64'h89AB, ST_BUSY);
		add_check(ACT_HALFWORD, 16'h2001, 1'b1, 33'h0_1234_5001, WIDTH_16, 64'hCDEF, ST_BUSY);
		add_check(ACT_HALFWORD, 16'h3ABC, 1'b1, 33'h0_1234_5ABC, WIDTH_32, 64'h89AB_CDEF,
			ST_BUSY);
		add_check(ACT_HALFWORD, 16'hA000, 1'b1, 33'h0_1234_5000, WIDTH_64, DIRECTED_ADJUST,
			ST_BUSY);
		add_req(ACT_HALFWORD, 16'hFFFF);
		add_req(ACT_HALFWORD, 16'hFFFF);
		add_req(ACT_HALFWORD, 16'h0004);
		add_check(ACT_HALFWORD, 16'h0000, 1'b0, '0, '0, '0, ST_BLKOVF);
		// Page offset at the image end
		add_check(ACT_BEGIN, 16'h0000, 1'b0, '0, '0, '0, ST_BUSY);
		add_req(ACT_HALFWORD, 16'hFFFF);
		add_req(ACT_HALFWORD, 16'hFFFF);
		add_req(ACT_HALFWORD, 16'h0008);
		add_check(ACT_HALFWORD, 16'h0000, 1'b0, '0, '0, '0, ST_PAGE);
		// Unknown entry type
		add_req(ACT_BEGIN, 16'h0000);
		add_req(ACT_HALFWORD, 16'h0000);
		add_req(ACT_HALFWORD, 16'h0000);
		add_req(ACT_HALFWORD, 16'h000A);
		add_req(ACT_HALFWORD, 16'h0000);
		add_check(ACT_HALFWORD, 16'hB123, 1'b0, '0, '0, '0, ST_TYPE);
	endfunction

	// ------------------------------------------------------------------
	// Random directories
	// ------------------------------------------------------------------

	function automatic logic [3:0] pick_entry_type();
		int unsigned pick;
		logic [3:0]  odd_type;
		pick = $urandom_range(0, 99);
		if (pick < 15) return TYPE_PAD;
		if (pick < 35) return TYPE_HIGH;
		if (pick < 55) return TYPE_LOW;
		if (pick < 75) return TYPE_HIGHLOW;
		if (pick < 98) return TYPE_DIR64;
		// Skip the DIR64 code among the unknown types
		odd_type = 4'($urandom_range(4, 14));
		if (odd_type >= TYPE_DIR64)
			odd_type = odd_type + 4'd1;
		return odd_type;
	endfunction

	task automatic run_directory();
		int unsigned nblk, total, pick, b, e;
		int unsigned ents[3];
		logic [31:0] img, off, dsize, page, bsize;
		logic [63:0] adj;
		logic [4:0]  cnt;

		// Plan the block layout
		nblk  = $urandom_range(1, 3);
		total = 0;
		for (b = 0; b < nblk; b++) begin
			ents[b] = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
			total  += 8 + 2 * ents[b];
		end

		// Choose a register setting around that layout
		img  = ($urandom_range(0, 99) < 20) ? 32'hFFFF_FFFF : ($urandom() | 32'h0001_0000);
		pick = $urandom_range(0, 99);
		if (pick < 20)
			off = img - total;
		else if (pick < 30)
			off = '0;
		else if (pick < 35)
			off = img;
		else
			off = $urandom_range(0, img - total - 1);
		pick = $urandom_range(0, 99);
		if (pick < 75)
			dsize = total;
		else if (pick < 85)
			dsize = total + 1;
		else if (pick < 95)
			dsize = total + 2 * $urandom_range(1, 8);
		else if (pick < 98)
			dsize = '0;
		else
			dsize = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 10)
			adj = '1;
		else if (pick < 20)
			adj = '0;
		else
			adj = {$urandom(), $urandom()};
		cnt = ($urandom_range(0, 99) < 10) ? 5'($urandom_range(0, 5)) : 5'($urandom_range(6, 16));

		wait_idle();
		write_reg(REG_IMAGE_SIZE, {32'h0, img});
		write_reg(REG_LOAD_ADJ, adj);
		write_reg(REG_DIR_OFFSET, {32'h0, off});
		write_reg(REG_DIR_SIZE, {32'h0, dsize});
		write_reg(REG_DIR_COUNT, {59'h0, cnt});
		setups++;

		// Stream the directory
		send(ACT_BEGIN, 16'($urandom()));
		for (b = 0; b < nblk; b++) begin
			page  = $urandom_range(0, img - 1);
			bsize = 8 + 2 * ents[b];
			pick  = $urandom_range(0, 99);
			if (pick < 3)
				bsize = $urandom_range(0, 7);
			else if (pick < 6)
				bsize = bsize | 32'd1;
			else if (pick < 8)
				bsize = $urandom();
			else if (pick < 10)
				page = $urandom_range(img, 32'hFFFF_FFFF);
			else if (pick < 15)
				page = img - 1;
			send(ACT_HALFWORD, page[15:0]);
			send(ACT_HALFWORD, page[31:16]);
			send(ACT_HALFWORD, bsize[15:0]);
			send(ACT_HALFWORD, bsize[31:16]);
			for (e = 0; e < ents[b]; e++)
				send(ACT_HALFWORD, {pick_entry_type(), 12'($urandom())});
		end

		// Trailing noise: stray halfwords and the odd restart
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 4))
				send(($urandom_range(0, 4) == 0) ? ACT_BEGIN : ACT_HALFWORD, 16'($urandom()));
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin : stimulus
		plan_row_t   row;
		int unsigned phase, n;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table
		build_directed();
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE) begin
				wait_idle();
				write_reg(row.reg_idx, row.value);
			end else begin
				push_request(row.act, row.hw, row.typed, row.want);
			end
		end

		// Random directories, with a stretch free of idle cycles
		phase = 0;
		while (requests_sent < REQUEST_TARGET) begin
			gaps_on = !(phase >= 20 && phase < 30);
			run_directory();
			phase++;
		end
		gaps_on = 1'b1;

		// Drain, then watch for stray results
		in_valid = 1'b0;
		for (n = 0; n < 5000 && expected_fixups.size() != 0; n++)
			@(negedge clk);
		if (expected_fixups.size() != 0) begin
			$error("%0d expected results never arrived", expected_fixups.size());
			fail_count++;
		end
		repeat (8) @(negedge clk);

		$display("Sent %0d requests (%0d acted on) over %0d register setups.",
			requests_sent, acted_requests, setups);
		$display("Compared %0d results, %0d of them carrying a fixup.",
			results_checked, fixups_checked);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
